// File: rtl/core/zone_trimmed_mean_distance_top_macros.svh
// Assertion macros shared by the checker of the zone trimmed mean block.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef ZONE_TRIMMED_MEAN_DISTANCE_TOP_MACROS_SVH
`define ZONE_TRIMMED_MEAN_DISTANCE_TOP_MACROS_SVH

// Consequent holds in the same cycle, outside reset.
`define ZTMD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ztmd assertion failed");

// Consequent holds in the next cycle, outside reset.
`define ZTMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ztmd assertion failed");

// Consequent holds in the next cycle, also checked across reset.
`define ZTMD_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ztmd assertion failed");

`endif

// File: rtl/core/ztmd_pkg.sv
// Types and constants of the zone trimmed mean distance block.
// No dependencies; used by every module of the block.
package ztmd_pkg;

  localparam int ZONES_DEFAULT = 16;

  localparam int DIST_W   = 12;
  localparam int PCT_W    = 7;
  localparam int STATUS_W = 8;
  localparam int RAW_W    = 16;
  localparam int VCNT_W   = 5;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK_A = 8'd5;
  localparam logic [STATUS_W-1:0] STATUS_OK_B = 8'd9;

  localparam logic [PCT_W-1:0]  TRIM_LOW_RESET  = 7'd10;
  localparam logic [PCT_W-1:0]  TRIM_HIGH_RESET = 7'd10;
  localparam logic [DIST_W-1:0] MIN_DIST_RESET  = 12'd30;
  localparam logic [DIST_W-1:0] MAX_DIST_RESET  = 12'd4000;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST  = 2'd3;

  // Division by 100 as multiplication by 2^20/100, exact for products below 43600.
  localparam int RECIP_W     = 14;
  localparam int RECIP_SHIFT = 20;
  localparam logic [RECIP_W-1:0] RECIP_100 = 14'd10486;

  typedef struct packed {
    logic [STATUS_W-1:0]      zone_status;
    logic signed [RAW_W-1:0]  zone_range_mm;
    logic                     last_zone;
  } ztmd_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] range_mm;
    logic [VCNT_W-1:0] valid_count;
    logic              used_median;
  } ztmd_out_t;

endpackage

// File: rtl/core/zone_trimmed_mean_distance_top.sv
// Zone trimmed mean distance: a zone word that is kept is inserted into a sorted store, each
// larger stored entry shifted up. A last zone then runs the trim math (skipped with no zone
// kept), then either sums the entries left after trimming and divides serially, or reads the
// median, and emits the result; input stalls meanwhile.
// Synchronous active-high reset clears the count and the result valid flag and restores the
// register defaults; the store itself is not cleared.
module zone_trimmed_mean_distance_top #(
  parameter int ZONES = ztmd_pkg::ZONES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ztmd_pkg::ztmd_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ztmd_pkg::ztmd_out_t            out_data,
  input  logic                           cfg_we,
  input  logic [ztmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ztmd_pkg::CFG_W-1:0]     cfg_data
);
  import ztmd_pkg::*;

  localparam int NW = $clog2(ZONES + 1);
  localparam int AW = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int PW = NW + PCT_W;
  localparam int MW = PW + RECIP_W;
  localparam int RW = PW + 2;
  localparam int SW = DIST_W + NW;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_CMP = 4'd2;
  localparam logic [3:0] S_TLO_A   = 4'd3;
  localparam logic [3:0] S_TLO_B   = 4'd4;
  localparam logic [3:0] S_THI_A   = 4'd5;
  localparam logic [3:0] S_THI_B   = 4'd6;
  localparam logic [3:0] S_CHK     = 4'd7;
  localparam logic [3:0] S_SUM_RD  = 4'd8;
  localparam logic [3:0] S_SUM_ACC = 4'd9;
  localparam logic [3:0] S_DIV_GO  = 4'd10;
  localparam logic [3:0] S_DIV_WT  = 4'd11;
  localparam logic [3:0] S_MED_RD  = 4'd12;
  localparam logic [3:0] S_MED     = 4'd13;
  localparam logic [3:0] S_EMIT    = 4'd14;

  logic [3:0]        state;
  logic [PCT_W-1:0]  trim_low;
  logic [PCT_W-1:0]  trim_high;
  logic [DIST_W-1:0] min_dist;
  logic [DIST_W-1:0] max_dist;

  logic [DIST_W-1:0] zone_mm;
  logic              last;
  logic [NW-1:0]     kept;
  logic [NW-1:0]     pos;
  logic [NW-1:0]     idx;
  logic [NW-1:0]     end_idx;
  logic [NW-1:0]     divisor;
  logic [PW-1:0]     lo;
  logic [MW-1:0]     prod;
  logic [SW-1:0]     sum;
  logic [DIST_W-1:0] res_dist;
  logic              res_med;

  logic              in_fire;
  logic              zone_ok;
  logic [PW-1:0]     mul_a;
  logic [RECIP_W-1:0] mul_b;
  logic [PCT_W-1:0]  pct_sel;
  logic [PW-1:0]     quot100;
  logic [PW-1:0]     trim_now;
  logic signed [RW-1:0] rem_now;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DIST_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DIST_W-1:0] mem_rdata;

  logic              div_start;
  logic              div_done;
  logic [SW-1:0]     div_quot;

  assign in_stall = state != S_IDLE;
  assign in_fire  = in_valid && !in_stall;

  assign zone_ok = (in_data.zone_status == STATUS_OK_A || in_data.zone_status == STATUS_OK_B)
                   && !in_data.zone_range_mm[RAW_W-1]
                   && in_data.zone_range_mm[RAW_W-2:0] >= (RAW_W-1)'(min_dist)
                   && in_data.zone_range_mm[RAW_W-2:0] <= (RAW_W-1)'(max_dist);

  always_comb begin
    if (state == S_TLO_A || state == S_THI_A) begin
      mul_a = PW'(state == S_TLO_A ? trim_low : trim_high);
      mul_b = RECIP_W'(kept);
    end else begin
      mul_a = prod[PW-1:0];
      mul_b = RECIP_100;
    end
  end

  assign pct_sel  = (state == S_THI_A) ? trim_low : trim_high;
  assign quot100  = PW'(prod[MW-1:RECIP_SHIFT]);
  assign trim_now = (pct_sel == '0) ? '0 : ((quot100 == '0) ? PW'(1) : quot100);
  assign rem_now  = RW'(kept) - RW'(lo) - RW'(trim_now);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos[AW-1:0];
    mem_wdata = zone_mm;
    mem_raddr = idx[AW-1:0];
    case (state)
      S_INS_RD: begin
        mem_raddr = AW'(pos - 1'b1);
        if (pos == '0) begin
          mem_we = 1'b1;
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (mem_rdata > zone_mm) begin
          mem_wdata = mem_rdata;
        end
      end
      S_MED_RD: begin
        mem_raddr = AW'(kept >> 1);
      end
      default: begin
      end
    endcase
  end

  assign div_start = state == S_DIV_GO;

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_low  <= TRIM_LOW_RESET;
      trim_high <= TRIM_HIGH_RESET;
      min_dist  <= MIN_DIST_RESET;
      max_dist  <= MAX_DIST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRIM_LOW:  trim_low  <= cfg_data[PCT_W-1:0];
        CFG_TRIM_HIGH: trim_high <= cfg_data[PCT_W-1:0];
        CFG_MIN_DIST:  min_dist  <= cfg_data[DIST_W-1:0];
        CFG_MAX_DIST:  max_dist  <= cfg_data[DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kept      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            zone_mm <= in_data.zone_range_mm[DIST_W-1:0];
            last    <= in_data.last_zone;
            pos     <= kept;
            if (zone_ok && kept < NW'(ZONES)) begin
              state <= S_INS_RD;
            end else if (in_data.last_zone) begin
              state <= S_TLO_A;
            end
          end
        end
        S_INS_RD: begin
          if (pos == '0) begin
            kept  <= kept + 1'b1;
            state <= last ? S_TLO_A : S_IDLE;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (mem_rdata > zone_mm) begin
            pos   <= pos - 1'b1;
            state <= S_INS_RD;
          end else begin
            kept  <= kept + 1'b1;
            state <= last ? S_TLO_A : S_IDLE;
          end
        end
        S_TLO_A: begin
          if (kept == '0) begin
            res_dist <= '0;
            res_med  <= 1'b0;
            state    <= S_EMIT;
          end else begin
            prod  <= mul_a * mul_b;
            state <= S_TLO_B;
          end
        end
        S_TLO_B: begin
          prod  <= mul_a * mul_b;
          state <= S_THI_A;
        end
        S_THI_A: begin
          lo    <= trim_now;
          prod  <= mul_a * mul_b;
          state <= S_THI_B;
        end
        S_THI_B: begin
          prod  <= mul_a * mul_b;
          state <= S_CHK;
        end
        S_CHK: begin
          if (rem_now > $signed(RW'(2))) begin
            idx     <= NW'(lo);
            end_idx <= NW'(RW'(kept) - RW'(trim_now));
            divisor <= NW'(rem_now);
            sum     <= '0;
            state   <= S_SUM_RD;
          end else begin
            state <= S_MED_RD;
          end
        end
        S_SUM_RD: begin
          state <= S_SUM_ACC;
        end
        S_SUM_ACC: begin
          sum <= sum + SW'(mem_rdata);
          idx <= idx + 1'b1;
          if (idx + 1'b1 == end_idx) begin
            state <= S_DIV_GO;
          end else begin
            state <= S_SUM_RD;
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WT;
        end
        S_DIV_WT: begin
          if (div_done) begin
            res_dist <= div_quot[DIST_W-1:0];
            res_med  <= 1'b0;
            state    <= S_EMIT;
          end
        end
        S_MED_RD: begin
          state <= S_MED;
        end
        S_MED: begin
          res_dist <= mem_rdata;
          res_med  <= 1'b1;
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_data.range_mm    <= res_dist;
            out_data.valid_count <= VCNT_W'(kept);
            out_data.used_median <= res_med;
            out_valid <= 1'b1;
            kept      <= '0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  ztmd_store #(
    .DEPTH(ZONES),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  ztmd_div #(
    .DW(SW),
    .VW(NW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sum),
    .divisor (divisor),
    .done    (div_done),
    .quotient(div_quot)
  );

endmodule

// File: rtl/core/ztmd_store.sv
// Sorted distance store: one write port and one registered read port.
// Uses ztmd_pkg for the distance width.
module ztmd_store #(
  parameter int DEPTH = ztmd_pkg::ZONES_DEFAULT,
  parameter int AW    = 4
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [ztmd_pkg::DIST_W-1:0]  wdata,
  input  logic [AW-1:0]                raddr,
  output logic [ztmd_pkg::DIST_W-1:0]  rdata
);
  import ztmd_pkg::*;

  logic [DIST_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/ztmd_div.sv
// Restoring divider that retires one quotient bit per cycle.
// Uses ztmd_pkg only by convention; no other dependencies.
module ztmd_div #(
  parameter int DW = 16,
  parameter int VW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  import ztmd_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem, quotient[DW-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CW'(DW);
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        if (fits) begin
          rem <= VW'(trial - {1'b0, divisor});
        end else begin
          rem <= VW'(trial);
        end
        quotient <= {quotient[DW-2:0], fits};
        cnt      <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/ztmd_checker.sv
// Port-level checker for the zone trimmed mean distance block, bound to the top level.
// Depends on ztmd_pkg and zone_trimmed_mean_distance_top_macros.svh.
`include "zone_trimmed_mean_distance_top_macros.svh"

module ztmd_checker #(
  parameter int ZONES = ztmd_pkg::ZONES_DEFAULT
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input ztmd_pkg::ztmd_in_t   in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input ztmd_pkg::ztmd_out_t  out_data
);
  import ztmd_pkg::*;

  // A stalled result word holds its value.
  `ZTMD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // Reset leaves no result word pending.
  `ZTMD_ASSERT_NEXT_ALWAYS(a_rst_empty, rst, !out_valid)

  // Accepting the last zone of a frame starts the result work.
  `ZTMD_ASSERT_NEXT(a_last_busy, in_valid && !in_stall && in_data.last_zone, in_stall)

  // A frame with no valid zone reports zero without the median fallback.
  `ZTMD_ASSERT_NOW(a_empty_frame,
    out_valid && out_data.valid_count == '0 && ZONES < 32,
    out_data.range_mm == '0 && !out_data.used_median)

endmodule

bind zone_trimmed_mean_distance_top ztmd_checker #(
  .ZONES(ZONES)
) u_ztmd_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
